// File: sv/dsg_pkg.sv
// Package: shared types, constants and register codes of the damped sinusoid generator.
`timescale 1ns / 1ps
package dsg_pkg;

	localparam int COS_TABLE_DEPTH_DEF = 1024;
	localparam int PADDR_W             = 5;
	localparam int PDATA_W             = 32;
	localparam int AMP_W               = 16;
	localparam int WORD_W              = 32;
	localparam int TOTAL_W             = 21;
	localparam int CNT_W               = 20;
	localparam int VALUE_W             = 17;

	localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = 16'd32767;
	localparam logic [WORD_W-1:0]  DECAY_RST        = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0]  STEP_RST         = 32'd0;
	localparam logic [WORD_W-1:0]  START_PHASE_RST  = 32'd0;
	localparam logic [TOTAL_W-1:0] TOTAL_RST        = 21'd1024;
	localparam logic [TOTAL_W-1:0] COUNT_LIMIT      = 21'h10_0000;
	localparam logic [WORD_W-1:0]  ENVELOPE_ONE     = 32'hFFFF_FFFF;

	// Fixed-point constants for building the cosine table at elaboration.
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;

	typedef enum logic [2:0] {
		REG_AMPLITUDE    = 3'd0,
		REG_DECAY_FACTOR = 3'd1,
		REG_PHASE_STEP   = 3'd2,
		REG_START_PHASE  = 3'd3,
		REG_SAMPLE_TOTAL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [AMP_W-1:0]   amplitude;
		logic [WORD_W-1:0]  decay_factor;
		logic [WORD_W-1:0]  phase_step;
		logic [WORD_W-1:0]  start_phase;
		logic [TOTAL_W-1:0] sample_total;
	} cfg_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;   // request taken; apply restart
		logic fetch;  // table read, amplitude * envelope
		logic mult;   // magnitude product, state advance
		logic emit;   // round and load the output register
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_FETCH = 2'd1,
		ST_MULT  = 2'd2,
		ST_ROUND = 2'd3
	} state_t;

endpackage

// File: sv/dsg_regs.sv
// Configuration register file behind an APB-style port.
`timescale 1ns / 1ps
module dsg_regs
	import dsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude    <= AMPLITUDE_RST;
			cfg_q.decay_factor <= DECAY_RST;
			cfg_q.phase_step   <= STEP_RST;
			cfg_q.start_phase  <= START_PHASE_RST;
			cfg_q.sample_total <= TOTAL_RST;
		end else if (wr_en) begin
			case (sel)
				REG_AMPLITUDE:    cfg_q.amplitude    <= pwdata[AMP_W-1:0];
				REG_DECAY_FACTOR: cfg_q.decay_factor <= pwdata;
				REG_PHASE_STEP:   cfg_q.phase_step   <= pwdata;
				REG_START_PHASE:  cfg_q.start_phase  <= pwdata;
				REG_SAMPLE_TOTAL: cfg_q.sample_total <= pwdata[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_AMPLITUDE:    prdata = PDATA_W'(cfg_q.amplitude);
			REG_DECAY_FACTOR: prdata = cfg_q.decay_factor;
			REG_PHASE_STEP:   prdata = cfg_q.phase_step;
			REG_START_PHASE:  prdata = cfg_q.start_phase;
			REG_SAMPLE_TOTAL: prdata = PDATA_W'(cfg_q.sample_total);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: sv/dsg_ctrl.sv
// Controller: sequences one request through fetch, multiply and round.
`timescale 1ns / 1ps
module dsg_ctrl
	import dsg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_MULT;
			ST_MULT:  state_d = ST_ROUND;
			ST_ROUND: if (slot_free) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_FETCH: cmd.fetch = 1'b1;
			ST_MULT:  cmd.mult  = 1'b1;
			ST_ROUND: cmd.emit  = slot_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/dsg_dp.sv
// Datapath: envelope, phase and count state, cosine ROM, multipliers and output register.
`timescale 1ns / 1ps
module dsg_dp
	import dsg_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  cmd_t                      cmd,
	input  logic                      restart,
	output logic signed [VALUE_W-1:0] sample_value,
	output logic [CNT_W-1:0]          sample_index,
	output logic                      last_sample
);

	localparam int     IW      = $clog2(COS_TABLE_DEPTH);
	localparam int     DW      = $clog2(COS_TABLE_DEPTH + 1);
	localparam int     PW      = WORD_W + DW;
	localparam longint DEPTH_L = COS_TABLE_DEPTH;
	localparam longint TAYLOR_DIV [1:6] = '{Q30_ONE * 2, Q30_ONE * 12, Q30_ONE * 30,
		Q30_ONE * 56, Q30_ONE * 90, Q30_ONE * 132};

	typedef logic signed [15:0] rom_t [COS_TABLE_DEPTH];

	// 32767*cos(2*pi*i/depth): quadrant fold, Q30 Taylor series, round to nearest.
	function automatic logic signed [15:0] cos_entry(longint i);
		longint a, x, x2, t, v, r;
		logic   neg;
		a   = 2 * i;
		neg = 1'b0;
		if (a > DEPTH_L) a = 2 * DEPTH_L - a;
		if (2 * a > DEPTH_L) begin
			neg = 1'b1;
			a   = DEPTH_L - a;
		end
		x  = (PI_Q30 * a + DEPTH_L / 2) / DEPTH_L;
		x2 = (x * x + Q30_ONE / 2) / Q30_ONE;
		t  = Q30_ONE;
		for (int k = 6; k >= 1; k--) t = Q30_ONE - (x2 * t) / TAYLOR_DIV[k];
		v = 32767 * t;
		if (v >= 0) r = (v + Q30_ONE / 2) / Q30_ONE;
		else r = -((-v + Q30_ONE / 2) / Q30_ONE);
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		if (neg) r = -r;
		return 16'(r);
	endfunction

	function automatic rom_t build_rom();
		rom_t tbl;
		for (int i = 0; i < COS_TABLE_DEPTH; i++) tbl[i] = cos_entry(longint'(i));
		return tbl;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	// Persistent generator state.
	logic [WORD_W-1:0] env_q;
	logic [WORD_W-1:0] phase_q;
	logic [CNT_W-1:0]  cnt_q;

	// Per-request working registers.
	logic signed [15:0]        rom_q;
	logic [CNT_W-1:0]          index_q;
	logic                      last_q;
	logic [AMP_W+WORD_W-1:0]   amp_env_q;
	logic [62:0]               prod_q;
	logic                      neg_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]          out_index_q;
	logic                      out_last_q;

	logic [PW-1:0]          idx_prod;
	logic [IW-1:0]          rom_addr;
	logic [TOTAL_W-1:0]     total_eff;
	logic [TOTAL_W-1:0]     cnt_inc;
	logic [15:0]            mag_full;
	logic [2*WORD_W-1:0]    env_prod;
	logic [63:0]            rounded;
	logic [VALUE_W-1:0]     q_mag;

	assign idx_prod = PW'({{DW{1'b0}}, phase_q} * PW'(COS_TABLE_DEPTH));
	assign rom_addr = idx_prod[WORD_W +: IW];

	always_comb begin
		if (cfg.sample_total == '0) total_eff = TOTAL_W'(1);
		else if (cfg.sample_total > COUNT_LIMIT) total_eff = COUNT_LIMIT;
		else total_eff = cfg.sample_total;
	end

	assign cnt_inc  = TOTAL_W'(cnt_q) + TOTAL_W'(1);
	assign mag_full = rom_q[15] ? 16'(-rom_q) : 16'(rom_q);
	assign env_prod = (2*WORD_W)'(env_q) * (2*WORD_W)'(cfg.decay_factor);
	assign rounded  = {1'b0, prod_q} + (64'd1 << 46);
	assign q_mag    = rounded[63:47];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q   <= ENVELOPE_ONE;
			phase_q <= START_PHASE_RST;
			cnt_q   <= '0;
		end else if ((cmd.load && restart) || (cmd.mult && last_q)) begin
			env_q   <= ENVELOPE_ONE;
			phase_q <= cfg.start_phase;
			cnt_q   <= '0;
		end else if (cmd.mult) begin
			env_q   <= env_prod[2*WORD_W-1:WORD_W];
			phase_q <= phase_q + cfg.phase_step;
			cnt_q   <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rom_q     <= COS_ROM[rom_addr];
			index_q   <= cnt_q;
			last_q    <= (cnt_inc >= total_eff);
			amp_env_q <= (AMP_W+WORD_W)'(cfg.amplitude) * (AMP_W+WORD_W)'(env_q);
		end
		if (cmd.mult) begin
			prod_q <= 63'(amp_env_q) * 63'(mag_full[14:0]);
			neg_q  <= rom_q[15];
		end
		if (cmd.emit) begin
			value_q     <= neg_q ? VALUE_W'(-q_mag) : VALUE_W'(q_mag);
			out_index_q <= index_q;
			out_last_q  <= last_q;
		end
	end

	assign sample_value = value_q;
	assign sample_index = out_index_q;
	assign last_sample  = out_last_q;

endmodule

// File: sv/damped_sinusoid_generator_top.sv
// Top level of the damped sinusoid generator: register file, controller and datapath.
`timescale 1ns / 1ps
//
//  channel   handshake            payload                                  dir
//  -------   ------------------   --------------------------------------   ---
//  in        in_valid / in_ready  restart                                  in
//  out       out_valid/out_ready  sample_value, sample_index, last_sample  out
//  cfg       psel/penable/pready  pwrite, paddr, pwdata, prdata            in
//
//  Each request passes these steps from acceptance to a loaded output register: cosine
//  ROM read with amplitude * envelope, then the magnitude product with the state
//  advance, then rounding. The controller walks those steps for one request at a time,
//  so with a free output a new request is taken only once the last one is rounded.
//  A held output stalls the round step; a new request is taken while a result waits.
//  Reset loads register defaults, envelope all ones, phase zero and counter zero.
//
module damped_sinusoid_generator_top
	import dsg_pkg::*;
#(
	parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      restart,
	// sample channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] sample_value,
	output logic [CNT_W-1:0]          sample_index,
	output logic                      last_sample,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	cfg_t cfg;
	cmd_t cmd;

	// Registers: amplitude, decay factor, phase step, start phase, length.
	dsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer and output valid flag.
	dsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Envelope/phase/count state, cosine ROM and arithmetic.
	dsg_dp #(
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.restart      (restart),
		.sample_value (sample_value),
		.sample_index (sample_index),
		.last_sample  (last_sample)
	);

endmodule

// File: bench/tb_damped_sinusoid_generator_top.sv
// Self-checking bench for the damped sinusoid generator: a sample predictor, request and sample traffic, register writes.
`timescale 1ns / 1ps

module tb_damped_sinusoid_generator_top;
	import dsg_pkg::*;

	localparam int TABLE_DEPTH   = COS_TABLE_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 12;        // margin well past one request's trip to the output
	localparam int HOLD_CYCLES   = 300;       // long receiver hold-off
	localparam int CYCLE_LIMIT   = 400000;    // slowest legal run is well below this
	localparam int RANDOM_PHASES = 12;
	localparam int MAX_ERR_LINES = 20;

	// Fixed-point constants for the local cosine table (Q30).
	localparam longint FIX_ONE = 64'sd1073741824;
	localparam longint PI_FIX  = 64'sd3373259426;

	// A register index past the end of the map; writes there must do nothing.
	localparam logic [2:0] UNUSED_IDX = 3'd5;

	typedef enum logic [1:0] {
		RX_ALWAYS  = 2'd0,
		RX_RANDOM  = 2'd1,
		RX_PATTERN = 2'd2
	} rx_style_t;

	// One expected sample, field for field as the sample channel carries it.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   index;
		logic               last;
	} sample_t;

	// ------------------------------------------------------------------
	// Clock, reset, DUT signals. Every input starts at a known value.
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic                      restart   = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] sample_value;
	logic [CNT_W-1:0]          sample_index;
	logic                      last_sample;
	logic                      psel      = 1'b0;
	logic                      penable   = 1'b0;
	logic                      pwrite    = 1'b0;
	logic [PADDR_W-1:0]        paddr     = '0;
	logic [PDATA_W-1:0]        pwdata    = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	damped_sinusoid_generator_top #(
		.COS_TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value),
		.sample_index (sample_index),
		.last_sample  (last_sample),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ------------------------------------------------------------------
	// Predictor state: register copy, envelope, phase, position in train.
	// ------------------------------------------------------------------
	cfg_t                     shadow;
	logic [WORD_W-1:0]        train_env;
	logic [WORD_W-1:0]        train_phase;
	logic [CNT_W-1:0]         train_pos;
	logic signed [15:0]       cos_rom [TABLE_DEPTH];

	logic    pending_requests[$];   // restart bits waiting to be offered
	sample_t expected_samples[$];   // predictions waiting for the sample channel
	sample_t sample_want;

	// Traffic shaping, set per phase by the sequence below.
	bit          burst_mode = 1'b0;
	rx_style_t   rx_style   = RX_ALWAYS;
	int unsigned hold_asked = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left  = 0;
	int unsigned rx_tick    = 0;
	logic [7:0]  rx_pattern = 8'hB7;

	int unsigned cycle_count   = 0;
	int unsigned error_count   = 0;
	int unsigned request_count = 0;
	int unsigned restart_count = 0;
	int unsigned checked_count = 0;
	int unsigned train_ends    = 0;
	int unsigned reg_writes    = 0;
	int unsigned reg_reads     = 0;

	// 32767*cos(2*pi*i/d): fold to the first quadrant, then a seven-term
	// Taylor series in Q30 evaluated Horner style, rounded to nearest.
	function automatic logic signed [15:0] taylor_cos(input longint i, input longint d);
		longint a, x, x2, t, v, r, den;
		int     k;
		bit     neg;
		neg = 1'b0;
		a   = 2 * i;
		if (a > d) a = 2 * d - a;
		if (2 * a > d) begin
			neg = 1'b1;
			a   = d - a;
		end
		x  = (PI_FIX * a + d / 2) / d;
		x2 = (x * x + FIX_ONE / 2) / FIX_ONE;
		t  = FIX_ONE;
		for (k = 6; k >= 1; k--) begin
			den = longint'(2 * k) * longint'(2 * k - 1);
			t   = FIX_ONE - (x2 * t) / (FIX_ONE * den);
		end
		v = 32767 * t;
		if (v >= 0) r = (v + FIX_ONE / 2) / FIX_ONE;
		else        r = -((-v + FIX_ONE / 2) / FIX_ONE);
		if (r > 32767)  r = 32767;
		if (r < -32767) r = -32767;
		if (neg) r = -r;
		return r[15:0];
	endfunction

	function automatic void restart_train();
		train_env   = ENVELOPE_ONE;
		train_phase = shadow.start_phase;
		train_pos   = '0;
	endfunction

	// Predicts the sample for one request and advances the local state.
	function automatic sample_t next_sample(input logic restart_bit);
		sample_t            s;
		logic [TOTAL_W-1:0] len;
		logic [63:0]        turn, prod;
		logic signed [15:0] c;
		logic [15:0]        mag;
		logic [16:0]        q;
		logic               is_last;
		if (restart_bit) restart_train();
		// zero acts as one, anything past the counter range is clamped
		len = shadow.sample_total;
		if (len == '0) len = TOTAL_W'(1);
		if (len > COUNT_LIMIT) len = COUNT_LIMIT;
		is_last = ({1'b0, train_pos} + 21'd1 >= len);

		turn = {32'd0, train_phase} * 64'(TABLE_DEPTH);
		c    = cos_rom[int'(turn[63:32])];
		mag  = (c < 0) ? 16'(-c) : 16'(c);
		prod = 64'(shadow.amplitude) * 64'(train_env) * 64'(mag);
		prod = prod + (64'd1 << 46);
		q    = prod[63:47];

		s.value = (c < 0) ? -q : q;
		s.index = train_pos;
		s.last  = is_last;

		if (is_last) begin
			restart_train();
		end else begin
			train_env   = 32'((64'(train_env) * 64'(shadow.decay_factor)) >> 32);
			train_phase = train_phase + shadow.phase_step;
			train_pos   = train_pos + 1'b1;
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= MAX_ERR_LINES)
			$display("ERROR @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Request driver: pops the pending queue, works in bursts with gaps.
	// Prediction happens here, at the edge where a request is accepted.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_samples.push_back(next_sample(restart));
				request_count++;
				if (restart) restart_count++;
			end
			// slot is free when nothing is offered or the offer just went through
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || pending_requests.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0) gap_left--;
				end else begin
					in_valid <= 1'b1;
					restart  <= pending_requests.pop_front();
					if (burst_left != 0) begin
						burst_left--;
					end else if (burst_mode) begin
						burst_left = $urandom_range(0, 12);
						gap_left   = $urandom_range(1, 7);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample receiver: long hold-off on demand, else its own stall style.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			rx_tick++;
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_style)
					RX_ALWAYS: begin
						out_ready <= 1'b1;
					end
					RX_RANDOM: begin
						out_ready <= ($urandom_range(0, 3) != 0);
					end
					default: begin
						// rotating mask, redrawn now and then; bit 0 forced so it never locks
						out_ready <= rx_pattern[0];
						if (rx_tick % 64 == 0)
							rx_pattern <= 8'($urandom()) | 8'h01;
						else
							rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample monitor: every accepted sample against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("sample with no request behind it", sample_value, 0);
			end else begin
				sample_want = expected_samples.pop_front();
				checked_count++;
				if (sample_want.last) train_ends++;
				if (sample_value !== sample_want.value)
					report_mismatch($sformatf("sample_value #%0d", checked_count),
						longint'(sample_value), longint'(sample_want.value));
				if (sample_index !== sample_want.index)
					report_mismatch($sformatf("sample_index #%0d", checked_count),
						sample_index, sample_want.index);
				if (last_sample !== sample_want.last)
					report_mismatch($sformatf("last_sample #%0d", checked_count),
						last_sample, sample_want.last);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples still owed",
				cycle_count, expected_samples.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Register access over the APB-style port (setup then access cycle).
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_AMPLITUDE:    shadow.amplitude    = data[AMP_W-1:0];
			REG_DECAY_FACTOR: shadow.decay_factor = data;
			REG_PHASE_STEP:   shadow.phase_step   = data;
			REG_START_PHASE:  shadow.start_phase  = data;
			REG_SAMPLE_TOTAL: shadow.sample_total = data[TOTAL_W-1:0];
			default: ;    // unmapped, no effect
		endcase
		reg_writes++;
	endtask

	task automatic check_reg(input logic [2:0] idx);
		logic [31:0] want;
		case (idx)
			REG_AMPLITUDE:    want = 32'(shadow.amplitude);
			REG_DECAY_FACTOR: want = shadow.decay_factor;
			REG_PHASE_STEP:   want = shadow.phase_step;
			REG_START_PHASE:  want = shadow.start_phase;
			default:          want = 32'(shadow.sample_total);
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_reads++;
		if (prdata !== want)
			report_mismatch($sformatf("read of register %0d", idx), prdata, want);
	endtask

	// Random register set with a bias toward the edges and toward short trains.
	task automatic random_config();
		logic [31:0] amp, decay, step, start;
		logic [31:0] len;
		int          k;
		case ($urandom_range(0, 7))
			0:       amp = 32'd0;
			1:       amp = 32'hFFFF;
			default: amp = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 7))
			0:       decay = 32'd0;
			1:       decay = 32'hFFFF_FFFF;
			2:       decay = $urandom();
			3:       decay = 32'hF000_0000 | $urandom();
			default: decay = 32'hFFFF_0000 | $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 7))
			0:       step = 32'd0;
			1:       step = 32'hFFFF_FFFF;
			default: step = $urandom();
		endcase
		case ($urandom_range(0, 7))
			0:       start = 32'd0;
			1:       start = 32'hFFFF_FFFF;
			default: start = $urandom();
		endcase
		case ($urandom_range(0, 9))
			0:       len = 32'd0;
			1:       len = $urandom_range(int'(COUNT_LIMIT) + 1, (1 << TOTAL_W) - 1);
			2:       len = 32'd1;
			3:       len = $urandom_range(64, int'(COUNT_LIMIT));
			default: len = $urandom_range(1, 48);
		endcase
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_DECAY_FACTOR, decay);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_START_PHASE, start);
		write_reg(REG_SAMPLE_TOTAL, len);
		for (k = 0; k <= int'(REG_SAMPLE_TOTAL); k++)
			check_reg(3'(k));
	endtask

	// Queues n restart bits, LSB first.
	task automatic queue_pattern(input logic [15:0] bits, input int n);
		int k;
		for (k = 0; k < n; k++)
			pending_requests.push_back(bits[k]);
	endtask

	// Returns once every request went out and every sample came back,
	// plus a margin so the pipeline is surely empty before a register write.
	task automatic settle();
		while (pending_requests.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin : sequence_main
		int ph, n, k, odds;
		for (k = 0; k < TABLE_DEPTH; k++)
			cos_rom[k] = taylor_cos(k, TABLE_DEPTH);
		shadow.amplitude    = AMPLITUDE_RST;
		shadow.decay_factor = DECAY_RST;
		shadow.phase_step   = STEP_RST;
		shadow.start_phase  = START_PHASE_RST;
		shadow.sample_total = TOTAL_RST;
		restart_train();

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed: reset defaults, phase zero, envelope at full scale.
		queue_pattern(16'b001, 3);
		settle();

		// Full amplitude, quarter-turn steps (+max, 0, -max, 0), three-sample trains.
		// The counter already stands at the new length, so the first sample ends a train.
		// A restart right after a train end follows.
		write_reg(REG_AMPLITUDE, 32'hFFFF);
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_SAMPLE_TOTAL, 32'd3);
		queue_pattern(16'b01_0000, 6);
		settle();

		// Half-turn start phase gives the most negative sample; length zero acts as one.
		write_reg(REG_START_PHASE, 32'h8000_0000);
		write_reg(REG_DECAY_FACTOR, 32'd0);
		write_reg(REG_SAMPLE_TOTAL, 32'd0);
		queue_pattern(16'b001, 3);
		settle();

		// Oversized length clamps to the counter range; zero decay kills the envelope.
		write_reg(REG_SAMPLE_TOTAL, 32'h001F_FFFF);
		queue_pattern(16'b000, 3);
		settle();

		// Zero amplitude, full step, and a write to an unmapped register.
		write_reg(REG_AMPLITUDE, 32'd0);
		write_reg(UNUSED_IDX, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_SAMPLE_TOTAL, 32'd1024);
		queue_pattern(16'b01, 2);
		settle();

		// One table entry per sample, then the length drops below the counter.
		write_reg(REG_AMPLITUDE, 32'hFFFF);
		write_reg(REG_DECAY_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_STEP, 32'h0040_0000);
		write_reg(REG_START_PHASE, 32'd0);
		queue_pattern(16'b0001, 4);
		settle();
		write_reg(REG_SAMPLE_TOTAL, 32'd2);
		queue_pattern(16'b000, 3);
		settle();

		// Random phases: fresh registers each time, mostly plain continue requests
		// with an occasional restart; the last phase is restart-heavy noise.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config();
			if (ph == 2) begin
				burst_mode = 1'b0;
				rx_style   = RX_ALWAYS;
			end else begin
				burst_mode = ($urandom_range(0, 3) != 0);
				rx_style   = rx_style_t'($urandom_range(0, 2));
			end
			odds = (ph == RANDOM_PHASES - 1) ? 2 : 32;
			n    = $urandom_range(45, 60);
			for (k = 0; k < n / 2; k++)
				pending_requests.push_back($urandom_range(0, odds - 1) == 0);
			// long receiver hold while requests keep coming: input must back up
			if (ph % 5 == 1) hold_asked++;
			// sender pauses mid-phase until every sample is back
			if (ph == 3) settle();
			for (k = n / 2; k < n; k++)
				pending_requests.push_back($urandom_range(0, odds - 1) == 0);
			settle();
		end

		$display("Run: %0d requests (%0d with restart), %0d samples checked, %0d train ends",
			request_count, restart_count, checked_count, train_ends);
		$display("Registers: %0d writes over %0d random settings plus edge values, %0d reads",
			reg_writes, RANDOM_PHASES, reg_reads);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/dsg_pkg.sv
sv/dsg_regs.sv
sv/dsg_ctrl.sv
sv/dsg_dp.sv
sv/damped_sinusoid_generator_top.sv
bench/tb_damped_sinusoid_generator_top.sv
